// ----- rtl/core/dpsn_pkg.sv -----
package dpsn_pkg;

   // lanes per full group (power of two)
   localparam int LANES = 4;
   localparam int IDX_W = $clog2(LANES + 1);
   localparam int LEN_W = 16;
   localparam int WORD_W = 32;

   // multiplier operand select
   localparam logic [1:0] MUL_PAIR     = 2'd0;
   localparam logic [1:0] MUL_FILE_ONE = 2'd1;
   localparam logic [1:0] MUL_TEMP_ONE = 2'd2;

   // addend select
   localparam logic [1:0] ADD_FILE    = 2'd0;
   localparam logic [1:0] ADD_NEGZERO = 2'd1;
   localparam logic [1:0] ADD_POSZERO = 2'd2;
   localparam logic [1:0] ADD_TEMP    = 2'd3;

   // result destination
   localparam logic [1:0] DST_FILE = 2'd0;
   localparam logic [1:0] DST_TEMP = 2'd1;
   localparam logic [1:0] DST_OUT  = 2'd2;

   // accumulator sets
   localparam logic [1:0] SET_DOT = 2'd0;
   localparam logic [1:0] SET_LHS = 2'd1;
   localparam logic [1:0] SET_RHS = 2'd2;

   localparam logic [WORD_W-1:0] FP_ONE      = 32'h3f80_0000;
   localparam logic [WORD_W-1:0] FP_POS_ZERO = 32'h0000_0000;
   localparam logic [WORD_W-1:0] FP_NEG_ZERO = 32'h8000_0000;

   typedef struct packed {
      logic             start;
      logic [1:0]       mul_sel;
      logic [1:0]       add_sel;
      logic [1:0]       dst;
      logic [1:0]       set;
      logic [IDX_W-1:0] idx;
      logic             load;
      logic             clear;
   } dpsn_cmd_type;

endpackage

// ----- rtl/core/dpsn_fma.sv -----
module dpsn_fma (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   input  logic [31:0] op_c,
   output logic        done,
   output logic [31:0] result
);
   import dpsn_pkg::*;

   localparam logic [2:0] F_IDLE  = 3'd0;
   localparam logic [2:0] F_UNPK  = 3'd1;
   localparam logic [2:0] F_ALIGN = 3'd2;
   localparam logic [2:0] F_ADD   = 3'd3;
   localparam logic [2:0] F_NORM  = 3'd4;
   localparam logic [2:0] F_RND   = 3'd5;

   localparam int MAG_W = 100;

   logic [2:0]  state_ff, state_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [47:0] prod_ff, prod_in;
   logic [23:0] mc_ff, mc_in;
   logic        sp_ff, sp_in, sc_ff, sc_in, cz_ff, cz_in;
   logic        spec_ff, spec_in, zero_ff, zero_in, sign_ff, sign_in;
   logic [31:0] res_ff, res_in;
   logic signed [11:0] d_ff, d_in, e_ff, e_in;
   logic [MAG_W-1:0] cf_ff, cf_in, mag_ff, mag_in;

   // unpack
   logic [7:0]  a_x, b_x, c_x, a_e, b_e, c_e;
   logic        a_zero, b_zero, c_zero, a_inf, b_inf, c_inf, a_nan, b_nan, c_nan;
   logic        p_inf, p_zero, is_nan, sp_w;
   logic signed [11:0] d_w;
   // align / add
   logic [11:0]      nd;
   logic [4:0]       sh;
   logic [23:0]      kept, lost;
   logic [MAG_W-1:0] pf, sum;
   logic [MAG_W:0]   diff, neg;
   logic [MAG_W-1:0] add_mag;
   logic             add_sign;
   // round
   logic signed [11:0] base;
   logic [23:0] q;
   logic        up;
   logic [33:0] total;

   always_comb begin
      a_x = a_ff[30:23];
      b_x = b_ff[30:23];
      c_x = c_ff[30:23];
      a_e = (a_x == 8'd0) ? 8'd1 : a_x;
      b_e = (b_x == 8'd0) ? 8'd1 : b_x;
      c_e = (c_x == 8'd0) ? 8'd1 : c_x;
      a_zero = (a_x == 8'd0) && (a_ff[22:0] == 23'd0);
      b_zero = (b_x == 8'd0) && (b_ff[22:0] == 23'd0);
      c_zero = (c_x == 8'd0) && (c_ff[22:0] == 23'd0);
      a_inf = (a_x == 8'hff) && (a_ff[22:0] == 23'd0);
      b_inf = (b_x == 8'hff) && (b_ff[22:0] == 23'd0);
      c_inf = (c_x == 8'hff) && (c_ff[22:0] == 23'd0);
      a_nan = (a_x == 8'hff) && (a_ff[22:0] != 23'd0);
      b_nan = (b_x == 8'hff) && (b_ff[22:0] != 23'd0);
      c_nan = (c_x == 8'hff) && (c_ff[22:0] != 23'd0);
      sp_w = a_ff[31] ^ b_ff[31];
      p_inf = a_inf | b_inf;
      p_zero = a_zero | b_zero;
      is_nan = a_nan | b_nan | c_nan | (a_inf & b_zero) | (b_inf & a_zero)
               | (p_inf & c_inf & (sp_w != c_ff[31]));
      // addend LSB position relative to the product frame
      d_w = $signed({4'd0, c_e}) - $signed({4'd0, a_e}) - $signed({4'd0, b_e})
            + 12'sd176;

      // alignment of the addend, dropped bits jammed into bit 0
      nd = 12'(-d_ff);
      sh = nd[4:0];
      kept = mc_ff >> sh;
      lost = mc_ff & ~(24'hff_ffff << sh);

      pf = {26'd0, prod_ff, 26'd0};
      sum = pf + cf_ff;
      diff = {1'b0, pf} - {1'b0, cf_ff};
      neg = -diff;
      if (sp_ff == sc_ff) begin
         add_mag = sum;
         add_sign = sp_ff;
      end else if (diff[MAG_W]) begin
         add_mag = neg[MAG_W-1:0];
         add_sign = sc_ff;
      end else begin
         add_mag = diff[MAG_W-1:0];
         add_sign = sp_ff;
      end

      base = e_ff + 12'sd225;
      q = mag_ff[99:76];
      up = mag_ff[75] & ((|mag_ff[74:0]) | q[0]);
      total = {base[10:0], 23'd0} + {10'd0, q} + {33'd0, up};
   end

   always_comb begin
      state_in = state_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      prod_in = prod_ff;
      mc_in = mc_ff;
      sp_in = sp_ff;
      sc_in = sc_ff;
      cz_in = cz_ff;
      spec_in = spec_ff;
      res_in = res_ff;
      zero_in = zero_ff;
      sign_in = sign_ff;
      d_in = d_ff;
      e_in = e_ff;
      cf_in = cf_ff;
      mag_in = mag_ff;
      done = 1'b0;
      result = 32'd0;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               a_in = op_a;
               b_in = op_b;
               c_in = op_c;
               state_in = F_UNPK;
            end
         end
         F_UNPK: begin
            prod_in = {|a_x, a_ff[22:0]} * {|b_x, b_ff[22:0]};
            mc_in = {|c_x, c_ff[22:0]};
            sp_in = sp_w;
            sc_in = c_ff[31];
            cz_in = c_zero;
            d_in = d_w;
            e_in = $signed({4'd0, a_e}) + $signed({4'd0, b_e}) - 12'sd326;
            zero_in = 1'b0;
            spec_in = 1'b1;
            res_in = c_ff;
            if (is_nan) begin
               res_in = 32'h7fc0_0000;
            end else if (p_inf) begin
               res_in = {sp_w, 31'h7f80_0000};
            end else if (c_inf) begin
               res_in = c_ff;
            end else if (p_zero && c_zero) begin
               res_in = {sp_w & c_ff[31], 31'd0};
            end else if (p_zero) begin
               res_in = c_ff;
            end else if (!c_zero && (d_w >= 12'sd76)) begin
               // product below a quarter unit of the addend
               res_in = c_ff;
            end else begin
               spec_in = 1'b0;
            end
            state_in = spec_in ? F_RND : F_ALIGN;
         end
         F_ALIGN: begin
            if (cz_ff) begin
               cf_in = '0;
            end else if (!d_ff[11]) begin
               cf_in = {76'd0, mc_ff} << d_ff[6:0];
            end else if (nd >= 12'd24) begin
               cf_in = {{(MAG_W-1){1'b0}}, 1'b1};
            end else begin
               cf_in = {76'd0, kept[23:1], kept[0] | (lost != 24'd0)};
            end
            state_in = F_ADD;
         end
         F_ADD: begin
            mag_in = add_mag;
            zero_in = (add_mag == '0);
            sign_in = (add_mag == '0) ? (sp_ff & sc_ff) : add_sign;
            state_in = (add_mag == '0) ? F_RND : F_NORM;
         end
         F_NORM: begin
            if (e_ff < -12'sd225) begin
               if (e_ff <= -12'sd233) begin
                  mag_in = {8'd0, mag_ff[99:9], mag_ff[8] | (mag_ff[7:0] != 8'd0)};
                  e_in = e_ff + 12'sd8;
               end else begin
                  mag_in = {1'b0, mag_ff[99:2], mag_ff[1] | mag_ff[0]};
                  e_in = e_ff + 12'sd1;
               end
            end else if (!mag_ff[99] && (e_ff > -12'sd225)) begin
               if ((mag_ff[99:92] == 8'd0) && (e_ff >= -12'sd217)) begin
                  mag_in = {mag_ff[91:0], 8'd0};
                  e_in = e_ff - 12'sd8;
               end else begin
                  mag_in = {mag_ff[98:0], 1'b0};
                  e_in = e_ff - 12'sd1;
               end
            end else begin
               state_in = F_RND;
            end
         end
         F_RND: begin
            done = 1'b1;
            if (spec_ff) begin
               result = res_ff;
            end else if (zero_ff) begin
               result = {sign_ff, 31'd0};
            end else if (total >= 34'h07f80_0000) begin
               result = {sign_ff, 31'h7f80_0000};
            end else begin
               result = {sign_ff, total[30:0]};
            end
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      prod_ff <= prod_in;
      mc_ff <= mc_in;
      sp_ff <= sp_in;
      sc_ff <= sc_in;
      cz_ff <= cz_in;
      spec_ff <= spec_in;
      res_ff <= res_in;
      zero_ff <= zero_in;
      sign_ff <= sign_in;
      d_ff <= d_in;
      e_ff <= e_in;
      cf_ff <= cf_in;
      mag_ff <= mag_in;
   end

endmodule

// ----- rtl/core/dpsn_datapath.sv -----
module dpsn_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  dpsn_pkg::dpsn_cmd_type cmd,
   input  logic [31:0]          req_lhs_value,
   input  logic [31:0]          req_rhs_value,
   output logic                 fma_done,
   output logic [31:0]          dot_product,
   output logic [31:0]          lhs_squared_norm,
   output logic [31:0]          rhs_squared_norm
);
   import dpsn_pkg::*;

   // per set: LANES lane sums, then the tail sum
   logic [WORD_W-1:0] file_ff [3][LANES+1];
   logic [WORD_W-1:0] file_in [3][LANES+1];
   logic [WORD_W-1:0] lhs_ff, lhs_in, rhs_ff, rhs_in, temp_ff, temp_in;
   logic [WORD_W-1:0] out_ff [3];
   logic [WORD_W-1:0] out_in [3];
   logic [WORD_W-1:0] file_rd, op_x, op_y, op_c, pair_x, pair_y, fma_res;

   dpsn_fma u_fma (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start),
      .op_a   (op_x),
      .op_b   (op_y),
      .op_c   (op_c),
      .done   (fma_done),
      .result (fma_res)
   );

   always_comb begin
      file_rd = file_ff[cmd.set][cmd.idx];
      case (cmd.set)
         SET_DOT: begin
            pair_x = lhs_ff;
            pair_y = rhs_ff;
         end
         SET_LHS: begin
            pair_x = lhs_ff;
            pair_y = lhs_ff;
         end
         default: begin
            pair_x = rhs_ff;
            pair_y = rhs_ff;
         end
      endcase
      case (cmd.mul_sel)
         MUL_PAIR: begin
            op_x = pair_x;
            op_y = pair_y;
         end
         MUL_FILE_ONE: begin
            op_x = file_rd;
            op_y = FP_ONE;
         end
         default: begin
            op_x = temp_ff;
            op_y = FP_ONE;
         end
      endcase
      case (cmd.add_sel)
         ADD_FILE:    op_c = file_rd;
         ADD_NEGZERO: op_c = FP_NEG_ZERO;
         ADD_POSZERO: op_c = FP_POS_ZERO;
         default:     op_c = temp_ff;
      endcase
   end

   always_comb begin
      file_in = file_ff;
      out_in = out_ff;
      temp_in = temp_ff;
      lhs_in = cmd.load ? req_lhs_value : lhs_ff;
      rhs_in = cmd.load ? req_rhs_value : rhs_ff;
      if (fma_done) begin
         case (cmd.dst)
            DST_FILE: file_in[cmd.set][cmd.idx] = fma_res;
            DST_TEMP: temp_in = fma_res;
            default:  out_in[cmd.set] = fma_res;
         endcase
      end
      if (cmd.clear) begin
         for (int s = 0; s < 3; s++) begin
            for (int i = 0; i <= LANES; i++) begin
               file_in[s][i] = FP_POS_ZERO;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 3; s++) begin
            for (int i = 0; i <= LANES; i++) begin
               file_ff[s][i] <= FP_POS_ZERO;
            end
         end
      end else begin
         file_ff <= file_in;
      end
      lhs_ff <= lhs_in;
      rhs_ff <= rhs_in;
      temp_ff <= temp_in;
      out_ff <= out_in;
   end

   assign dot_product = out_ff[SET_DOT];
   assign lhs_squared_norm = out_ff[SET_LHS];
   assign rhs_squared_norm = out_ff[SET_RHS];

endmodule

// ----- rtl/core/dpsn_ctrl.sv -----
module dpsn_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [dpsn_pkg::LEN_W-1:0] vector_length,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic                      fma_done,
   output dpsn_pkg::dpsn_cmd_type    cmd
);
   import dpsn_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_WOUT  = 2'd3;

   localparam logic [1:0] PH_LANE = 2'd0;
   localparam logic [1:0] PH_TAIL = 2'd1;
   localparam logic [1:0] PH_RED  = 2'd2;

   logic [1:0]       state_ff, state_in, phase_ff, phase_in, set_ff, set_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             step_ff, step_in, last_ff, last_in, rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [LEN_W:0]   len, full;
   logic             accept, elem_done;

   assign len = (vector_length == '0) ? {1'b1, {LEN_W{1'b0}}} : {1'b0, vector_length};
   assign full = (LEN_W+1)'((len / (LEN_W+1)'(LANES)) * (LEN_W+1)'(LANES));
   assign req_stall = reset | (state_ff != ST_IDLE);
   assign accept = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.start = (state_ff == ST_ISSUE);
      cmd.set = set_ff;
      cmd.load = accept;
      case (phase_ff)
         PH_LANE: begin
            cmd.mul_sel = MUL_PAIR;
            cmd.add_sel = ADD_FILE;
            cmd.dst = DST_FILE;
            cmd.idx = idx_ff;
         end
         PH_TAIL: begin
            cmd.idx = IDX_W'(LANES);
            if (!step_ff) begin
               cmd.mul_sel = MUL_PAIR;
               cmd.add_sel = ADD_NEGZERO;
               cmd.dst = DST_TEMP;
            end else begin
               cmd.mul_sel = MUL_TEMP_ONE;
               cmd.add_sel = ADD_FILE;
               cmd.dst = DST_FILE;
            end
         end
         default: begin
            cmd.idx = idx_ff;
            if (idx_ff == IDX_W'(LANES)) begin
               cmd.mul_sel = MUL_TEMP_ONE;
               cmd.add_sel = ADD_FILE;
               cmd.dst = DST_OUT;
            end else begin
               cmd.mul_sel = MUL_FILE_ONE;
               cmd.add_sel = (idx_ff == '0) ? ADD_POSZERO : ADD_TEMP;
               cmd.dst = DST_TEMP;
            end
         end
      endcase
      cmd.clear = (state_ff == ST_WAIT) && fma_done && (phase_ff == PH_RED)
                  && (set_ff == SET_RHS) && (idx_ff == IDX_W'(LANES));
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      set_in = set_ff;
      idx_in = idx_ff;
      step_in = step_ff;
      last_in = last_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      elem_done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               phase_in = ({1'b0, count_ff} < full) ? PH_LANE : PH_TAIL;
               set_in = SET_DOT;
               step_in = 1'b0;
               idx_in = IDX_W'(count_ff % LEN_W'(LANES));
               last_in = (({1'b0, count_ff} + 1'b1) >= len);
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (fma_done) begin
               state_in = ST_ISSUE;
               case (phase_ff)
                  PH_LANE: begin
                     if (set_ff == SET_RHS) begin
                        elem_done = 1'b1;
                     end else begin
                        set_in = set_ff + 2'd1;
                     end
                  end
                  PH_TAIL: begin
                     step_in = ~step_ff;
                     if (step_ff) begin
                        if (set_ff == SET_RHS) begin
                           elem_done = 1'b1;
                        end else begin
                           set_in = set_ff + 2'd1;
                        end
                     end
                  end
                  default: begin
                     if (idx_ff != IDX_W'(LANES)) begin
                        idx_in = idx_ff + 1'b1;
                     end else begin
                        idx_in = '0;
                        if (set_ff == SET_RHS) begin
                           rsp_valid_in = 1'b1;
                           count_in = '0;
                           state_in = ST_IDLE;
                        end else begin
                           set_in = set_ff + 2'd1;
                        end
                     end
                  end
               endcase
               if (elem_done) begin
                  if (last_ff) begin
                     phase_in = PH_RED;
                     set_in = SET_DOT;
                     idx_in = '0;
                     state_in = ST_WOUT;
                  end else begin
                     count_in = count_ff + 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            // previous result must leave the output registers first
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_ISSUE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_LANE;
         set_ff <= SET_DOT;
         idx_ff <= '0;
         step_ff <= 1'b0;
         last_ff <= 1'b0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         set_ff <= set_in;
         idx_ff <= idx_in;
         step_ff <= step_in;
         last_ff <= last_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/dot_product_and_squared_norms_top.sv -----
// Dot product and squared norms of two fp32 vectors.
// Request channel: one element pair (req_lhs_value, req_rhs_value) per
// request, valid/stall handshake. Response channel: rsp_dot_product,
// rsp_lhs_squared_norm, rsp_rhs_squared_norm, one response per vector,
// issued after the last element pair (vector_length pairs; 0 means 65536).
// Register vector_length sits at byte address 0 of the APB port.
// All math is binary32, round to nearest even, one shared iterative FMA.
// An FMA op is issued, then runs unpack, align, add, normalize and round;
// a special case (NaN, inf, zero operand, negligible product) skips from
// unpack to round, and a zero sum skips normalize. A lane element costs 3
// ops, a tail element 6 ops; the input is held until an element's ops are
// done. The last element then waits for the output registers and runs a
// 15-op reduction before the response is valid.
// req_stall is high in reset and while an element or the reduction is
// being worked on, also while a stalled pending response holds the
// reduction back. Next-vector elements enter while a response waits.
// Reset (synchronous) clears all sums, the element position, and sets
// vector_length to 1.
module dot_product_and_squared_norms_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_lhs_value,
   input  logic [31:0] req_rhs_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_dot_product,
   output logic [31:0] rsp_lhs_squared_norm,
   output logic [31:0] rsp_rhs_squared_norm,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import dpsn_pkg::*;

   logic [LEN_W-1:0] vlen_ff, vlen_in;
   logic             vlen_hit;
   logic             fma_done;
   dpsn_cmd_type     cmd;

   // register index is paddr[2]; only index 0 exists
   assign vlen_hit = (paddr[2] == 1'b0);
   assign pready = 1'b1;
   assign prdata = vlen_hit ? {{(32-LEN_W){1'b0}}, vlen_ff} : 32'd0;

   always_comb begin
      vlen_in = vlen_ff;
      if (psel && penable && pwrite && vlen_hit) begin
         vlen_in = pwdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff <= LEN_W'(1);
      end else begin
         vlen_ff <= vlen_in;
      end
   end

   dpsn_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .vector_length (vlen_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .fma_done      (fma_done),
      .cmd           (cmd)
   );

   dpsn_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_lhs_value    (req_lhs_value),
      .req_rhs_value    (req_rhs_value),
      .fma_done         (fma_done),
      .dot_product      (rsp_dot_product),
      .lhs_squared_norm (rsp_lhs_squared_norm),
      .rhs_squared_norm (rsp_rhs_squared_norm)
   );

endmodule
